@@ design/dslr_pkg.sv @@
package dslr_pkg;

  // Coordinate width and the widths that follow from it
  localparam int COORD_BITS = 16;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int THR_W      = COORD_BITS + 3;
  localparam int DEC_W      = COORD_BITS + 4;
  localparam int CNT_W      = COORD_BITS - 1;

  // Pixels produced by one command at most
  localparam int MAX_PIX = 4;
  localparam int COUNT_W = $clog2(MAX_PIX + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } cmd_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   done;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    pixel_t [MAX_PIX-1:0]      pix;
  } burst_t;

endpackage

@@ design/dslr_if.sv @@
interface dslr_cmd_if import dslr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   command;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dslr_pix_if import dslr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   line_done;

  modport source (output valid, pixel_x, pixel_y, line_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, line_done, output ready);
endinterface

@@ design/double_step_line_rasterizer_top.sv @@
// A command word is held in the input register and is committed once the output queue can take
// its pixels; its pixels are then presented from the output queue.
// A step command yields up to four pixels, sent one per cycle from the output queue while pix.ready
// is high; a start command yields one pixel. A new burst can load as the last pixel of the previous one leaves.
// Reset: rst is synchronous; it empties both registers and leaves the rasterizer idle.
module double_step_line_rasterizer_top import dslr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dslr_cmd_if.sink    cmd,
  dslr_pix_if.source  pix
);

  cmd_word_t word;
  logic      word_valid;
  logic      load_ok;
  logic      commit;
  burst_t    burst;

  // Commit the held command when the output queue can take its pixels
  assign commit = word_valid && load_ok;

  dslr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .take       (commit),
    .word       (word),
    .word_valid (word_valid)
  );

  dslr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .word   (word),
    .commit (commit),
    .burst  (burst)
  );

  dslr_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .burst   (burst),
    .load    (commit),
    .load_ok (load_ok),
    .pix     (pix)
  );

endmodule

@@ design/dslr_in_reg.sv @@
module dslr_in_reg import dslr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dslr_cmd_if.sink   cmd,
  input  logic       take,
  output cmd_word_t  word,
  output logic       word_valid
);

  // Take a new word whenever the register is empty or being drained
  assign cmd.ready = !word_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      word_valid <= 1'b1;
    end else if (take) begin
      word_valid <= 1'b0;
    end
  end

  // Capture the payload; no reset needed
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      word.command <= cmd_t'(cmd.command);
      word.start_x <= cmd.start_x;
      word.start_y <= cmd.start_y;
      word.end_x   <= cmd.end_x;
      word.end_y   <= cmd.end_y;
    end
  end

endmodule

@@ design/dslr_core.sv @@
module dslr_core import dslr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t word,
  input  logic      commit,
  output burst_t    burst
);

  // Line state
  coord_t front_x, front_x_next;
  coord_t front_y, front_y_next;
  coord_t back_x, back_x_next;
  coord_t back_y, back_y_next;
  logic   x_negative, x_negative_next;
  logic   y_negative, y_negative_next;
  logic   x_major, x_major_next;
  logic   shallow_regime, shallow_regime_next;
  logic   active, active_next;
  logic signed [DEC_W-1:0] decision, decision_next;
  logic signed [THR_W-1:0] threshold, threshold_next;
  logic signed [DEC_W-1:0] increment_one, increment_one_next;
  logic signed [DEC_W-1:0] increment_two, increment_two_next;
  logic [CNT_W-1:0]        steps_left, steps_left_next;
  logic [1:0]              leftover, leftover_next;

  // Setup terms for a start command
  logic signed [DELTA_W-1:0] dx, dy;
  logic [COORD_BITS-1:0]     adx, ady, big, little, big_m1;
  logic signed [DEC_W-1:0]   s_ext, b_ext, inc2_s, thr_wide, inc1_s, dec_s;
  logic                      shallow_s, x_major_s;

  assign dx        = DELTA_W'(word.end_x) - DELTA_W'(word.start_x);
  assign dy        = DELTA_W'(word.end_y) - DELTA_W'(word.start_y);
  assign adx       = dx[DELTA_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign ady       = dy[DELTA_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  assign x_major_s = adx > ady;
  assign big       = x_major_s ? adx : ady;
  assign little    = x_major_s ? ady : adx;
  assign big_m1    = big - COORD_BITS'(1);
  assign s_ext     = $signed(DEC_W'(little));
  assign b_ext     = $signed(DEC_W'(big));
  assign inc2_s    = (s_ext <<< 2) - (b_ext <<< 1);
  assign shallow_s = inc2_s[DEC_W-1];
  assign thr_wide  = shallow_s ? (s_ext <<< 1) : ((s_ext - b_ext) <<< 1);
  assign inc1_s    = thr_wide <<< 1;
  assign dec_s     = shallow_s ? (inc1_s - b_ext) : (inc1_s + b_ext);

  // Decision for a double step
  logic signed [DEC_W-1:0] thr_ext;
  logic       go_diag, below, m1, m2, last_pair;
  logic [1:0] msum;

  assign thr_ext   = DEC_W'(threshold);
  assign below     = decision < thr_ext;
  assign go_diag   = shallow_regime ? (decision < 0) : (decision > 0);
  assign m1        = go_diag ? !shallow_regime : !below;
  assign m2        = go_diag ? !shallow_regime : below;
  assign msum      = {1'b0, m1} + {1'b0, m2};
  assign last_pair = (steps_left == CNT_W'(1)) && (leftover == 2'd0);

  // Minor steps of the leftover tail
  logic       t1, t2, t3;
  logic [1:0] tsum;

  always_comb begin
    if (shallow_regime) begin
      priority if (decision < 0) begin
        t1 = 1'b0; t2 = 1'b0; t3 = 1'b0;
      end else if (below) begin
        t1 = 1'b0; t2 = 1'b1; t3 = 1'b0;
      end else begin
        t1 = 1'b1; t2 = 1'b0; t3 = 1'b1;
      end
    end else begin
      priority if (decision > 0) begin
        t1 = 1'b1; t2 = 1'b1; t3 = 1'b1;
      end else if (below) begin
        t1 = 1'b0; t2 = 1'b1; t3 = 1'b0;
      end else begin
        t1 = 1'b1; t2 = 1'b0; t3 = decision > thr_ext;
      end
    end
  end

  assign tsum = {1'b0, t1} + {1'b0, t2};

  // Signed offset of 0..2 pixels along one axis
  function automatic coord_t offs(logic [1:0] m, logic neg);
    coord_t mag;
    mag = COORD_BITS'(m);
    return neg ? -mag : mag;
  endfunction

  // Move a point along major and minor axes, backwards for the back end
  function automatic pixel_t move_pt(coord_t px, coord_t py, logic [1:0] maj,
                                     logic [1:0] mn, logic back);
    pixel_t p;
    p.x    = px + offs(x_major ? maj : mn, x_negative ^ back);
    p.y    = py + offs(x_major ? mn : maj, y_negative ^ back);
    p.done = 1'b0;
    return p;
  endfunction

  // Next state and the pixels of this command
  always_comb begin
    front_x_next        = front_x;
    front_y_next        = front_y;
    back_x_next         = back_x;
    back_y_next         = back_y;
    x_negative_next     = x_negative;
    y_negative_next     = y_negative;
    x_major_next        = x_major;
    shallow_regime_next = shallow_regime;
    active_next         = active;
    decision_next       = decision;
    threshold_next      = threshold;
    increment_one_next  = increment_one;
    increment_two_next  = increment_two;
    steps_left_next     = steps_left;
    leftover_next       = leftover;
    burst               = '0;

    unique case (word.command)
      CMD_START: begin
        front_x_next    = word.start_x;
        front_y_next    = word.start_y;
        back_x_next     = word.end_x;
        back_y_next     = word.end_y;
        x_negative_next = dx[DELTA_W-1];
        y_negative_next = dy[DELTA_W-1];
        x_major_next    = x_major_s;
        if (big != '0) begin
          steps_left_next     = CNT_W'(big_m1 >> 2);
          leftover_next       = big_m1[1:0];
          shallow_regime_next = shallow_s;
          threshold_next      = THR_W'(thr_wide);
          increment_one_next  = inc1_s;
          increment_two_next  = inc2_s;
          decision_next       = dec_s;
        end else begin
          steps_left_next     = '0;
          leftover_next       = 2'd0;
          shallow_regime_next = 1'b0;
          threshold_next      = '0;
          increment_one_next  = '0;
          increment_two_next  = '0;
          decision_next       = '0;
        end
        active_next       = big > COORD_BITS'(1);
        burst.count       = COUNT_W'(1);
        burst.pix[0].x    = word.start_x;
        burst.pix[0].y    = word.start_y;
        burst.pix[0].done = !(big > COORD_BITS'(1));
      end
      CMD_STEP: begin
        priority if (!active) begin
          burst.count = '0;
        end else if (steps_left != '0) begin
          // Two pixels from the front, two mirrored from the back
          burst.count  = COUNT_W'(MAX_PIX);
          burst.pix[0] = move_pt(front_x, front_y, 2'd1, {1'b0, m1}, 1'b0);
          burst.pix[1] = move_pt(front_x, front_y, 2'd2, msum, 1'b0);
          burst.pix[2] = move_pt(back_x, back_y, 2'd1, {1'b0, m1}, 1'b1);
          burst.pix[3] = move_pt(back_x, back_y, 2'd2, msum, 1'b1);
          burst.pix[3].done = last_pair;
          front_x_next    = burst.pix[1].x;
          front_y_next    = burst.pix[1].y;
          back_x_next     = burst.pix[3].x;
          back_y_next     = burst.pix[3].y;
          decision_next   = go_diag ? decision + increment_one : decision + increment_two;
          steps_left_next = steps_left - CNT_W'(1);
          active_next     = !last_pair;
        end else begin
          // Leftover tail of one to three pixels
          burst.count  = COUNT_W'(leftover);
          burst.pix[0] = move_pt(front_x, front_y, 2'd1, {1'b0, t1}, 1'b0);
          burst.pix[1] = move_pt(front_x, front_y, 2'd2, tsum, 1'b0);
          burst.pix[2] = move_pt(back_x, back_y, 2'd1, {1'b0, t3}, 1'b1);
          for (int i = 0; i < 3; i++) begin
            burst.pix[i].done = (leftover == 2'(i + 1));
          end
          leftover_next = 2'd0;
          active_next   = 1'b0;
        end
      end
    endcase
  end

  // Update the line state on each committed command
  always_ff @(posedge clk) begin
    if (rst) begin
      front_x        <= '0;
      front_y        <= '0;
      back_x         <= '0;
      back_y         <= '0;
      x_negative     <= 1'b0;
      y_negative     <= 1'b0;
      x_major        <= 1'b0;
      shallow_regime <= 1'b0;
      active         <= 1'b0;
      decision       <= '0;
      threshold      <= '0;
      increment_one  <= '0;
      increment_two  <= '0;
      steps_left     <= '0;
      leftover       <= 2'd0;
    end else if (commit) begin
      front_x        <= front_x_next;
      front_y        <= front_y_next;
      back_x         <= back_x_next;
      back_y         <= back_y_next;
      x_negative     <= x_negative_next;
      y_negative     <= y_negative_next;
      x_major        <= x_major_next;
      shallow_regime <= shallow_regime_next;
      active         <= active_next;
      decision       <= decision_next;
      threshold      <= threshold_next;
      increment_one  <= increment_one_next;
      increment_two  <= increment_two_next;
      steps_left     <= steps_left_next;
      leftover       <= leftover_next;
    end
  end

  logic burst_done;
  assign burst_done = burst.pix[0].done || burst.pix[1].done ||
                      burst.pix[2].done || burst.pix[3].done;

  // A line only ends on a committed word that flags its last pixel
  a_end_flagged: assert property (@(posedge clk) disable iff (rst)
    $fell(active) |-> $past(commit && burst_done))
    else $error("line ended without a flagged last pixel");

  // A step with no line in progress produces nothing
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (commit && word.command == CMD_STEP && !active) |-> burst.count == '0)
    else $error("idle step produced pixels");

  // An active line with no double steps left still has a tail
  a_tail_left: assert property (@(posedge clk) disable iff (rst)
    (active && steps_left == '0) |-> leftover != 2'd0)
    else $error("active line with nothing left to draw");

endmodule

@@ design/dslr_emit.sv @@
module dslr_emit import dslr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  burst_t      burst,
  input  logic        load,
  output logic        load_ok,
  dslr_pix_if.source  pix
);

  pixel_t [MAX_PIX-1:0] slots;
  logic [COUNT_W-1:0]   count;

  // Head slot drives the output word
  assign pix.valid     = count != '0;
  assign pix.pixel_x   = slots[0].x;
  assign pix.pixel_y   = slots[0].y;
  assign pix.line_done = slots[0].done;

  // Free now, or free once the last word leaves this cycle
  assign load_ok = (count == '0) || (count == COUNT_W'(1) && pix.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (pix.valid && pix.ready) begin
      count <= count - COUNT_W'(1);
    end
  end

  // Load a new burst or shift the queue down by one
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= burst.pix;
    end else if (pix.valid && pix.ready) begin
      slots[MAX_PIX-2:0] <= slots[MAX_PIX-1:1];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_PIX))
    else $error("pixel queue overfilled");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> load_ok)
    else $error("burst loaded over pending pixels");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!load && pix.valid && pix.ready) |=> count == $past(count) - COUNT_W'(1))
    else $error("pixel queue did not drain by one");

endmodule
